/* rtl/core/rhwf_pkg.sv */
// Shared types, codes and constants of the right-hand wall follower.
`timescale 1ns / 1ps
`default_nettype none

package rhwf_pkg;

   localparam int POS_W         = 6;
   localparam int MAX_SIDE      = 64;
   localparam int DEF_GRID_COLS = 64;
   localparam int DEF_GRID_ROWS = 64;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 6;
   localparam int MARK_W        = 4;

   localparam logic OP_STEP    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_START_COL = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_ROW = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_DIR = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GOAL_COL  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_GOAL_ROW  = 3'd4;

   typedef enum logic [1:0] {
      ST_RUN  = 2'd0,
      ST_GOAL = 2'd1,
      ST_LOOP = 2'd2,
      ST_OFF  = 2'd3
   } status_type;

   typedef struct packed {
      logic [POS_W-1:0] start_col;
      logic [POS_W-1:0] start_row;
      logic [1:0]       start_dir;
      logic [POS_W-1:0] goal_col;
      logic [POS_W-1:0] goal_row;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [1:0]       heading;
      logic             turned_last;
      status_type       status;
   } walker_type;

   typedef struct packed {
      logic              restart;
      logic              moved;
      logic              mark_we;
      logic [MARK_W-1:0] mark_wdata;
   } step_ctl_type;

   localparam cfg_type CFG_RESET = '{
      start_col: 6'd0,
      start_row: 6'd0,
      start_dir: 2'd0,
      goal_col:  6'd63,
      goal_row:  6'd63
   };

endpackage

`default_nettype wire

/* rtl/core/right_hand_wall_follower.sv */
// Top level of the right-hand wall follower: item stages, walker state, mark store, registers.
//
// Walks a grid maze by the right-hand rule, one step per item, taking one item
// per clock cycle when the result side keeps up and no sweep runs; an item is
// held in the input register, then its result in the result register. The visited
// marks of the current cell are held next to the walker state and refreshed from
// the mark RAM, read at the next position as the walker state is loaded, so steps
// run back to back. After reset and after every restart item the mark RAM is
// swept clear one cell per cycle over all min(GRID_COLS,64) * min(GRID_ROWS,64)
// cells (4096 by default); the restart result is delivered at once, and the next
// item waits in the input register until the sweep ends. Register writes are
// taken at any time; start values take effect at the next restart, goal values at once.
`timescale 1ns / 1ps
`default_nettype none

module right_hand_wall_follower
   import rhwf_pkg::*;
#(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [3:0] open_dirs, [7:4] zero
   input  wire logic [0:0]            req_tuser,   // [0] opcode
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,   // [5:0] pos_col, [11:6] pos_row,
                                                   // [13:12] heading_out, [15:14] status
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ColLim = (GRID_COLS < MAX_SIDE) ? GRID_COLS : MAX_SIDE;
   localparam int RowLim = (GRID_ROWS < MAX_SIDE) ? GRID_ROWS : MAX_SIDE;
   localparam int Depth  = ColLim * RowLim;
   localparam int AddrW  = $clog2(Depth);

   localparam walker_type WalkerReset = '{
      col:         CFG_RESET.start_col,
      row:         CFG_RESET.start_row,
      heading:     CFG_RESET.start_dir,
      turned_last: 1'b0,
      status:      ST_RUN
   };

   function automatic logic [AddrW-1:0] cell_addr(input logic [POS_W-1:0] col,
                                                   input logic [POS_W-1:0] row);
      int unsigned idx;
      idx = int'(row) * ColLim + int'(col);
      return idx[AddrW-1:0];
   endfunction

   cfg_type           cfg_ff, cfg_in;
   logic              in_valid_ff, in_valid_in;
   logic              in_op_ff;
   logic [3:0]        in_open_ff;
   walker_type        walker_ff, walker_in;
   walker_type        step_nxt;
   step_ctl_type      step_ctl;
   logic [MARK_W-1:0] mark_hold_ff, mark_hold_in;
   logic              use_mem_ff, use_mem_in;
   logic              clear_busy_ff, clear_busy_in;
   logic [AddrW-1:0]  clear_addr_ff, clear_addr_in;
   logic              out_valid_ff, out_valid_in;
   logic [15:0]       out_data_ff;
   logic [MARK_W-1:0] mem_rdata;
   logic [MARK_W-1:0] cur_mark;
   logic              mem_we;
   logic [AddrW-1:0]  mem_waddr;
   logic [MARK_W-1:0] mem_wdata;
   logic              fire;

   assign fire       = in_valid_ff && !clear_busy_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign cur_mark   = use_mem_ff ? mem_rdata : mark_hold_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_START_COL: cfg_in.start_col = csr_wdata;
            CSR_START_ROW: cfg_in.start_row = csr_wdata;
            CSR_START_DIR: cfg_in.start_dir = csr_wdata[1:0];
            CSR_GOAL_COL:  cfg_in.goal_col  = csr_wdata;
            CSR_GOAL_ROW:  cfg_in.goal_row  = csr_wdata;
            default:       cfg_in           = cfg_ff;
         endcase
      end
   end

   rhwf_step #(
      .GRID_COLS(GRID_COLS),
      .GRID_ROWS(GRID_ROWS)
   ) u_step (
      .opcode   (in_op_ff),
      .open_dirs(in_open_ff),
      .cfg      (cfg_ff),
      .cur      (walker_ff),
      .cur_mark (cur_mark),
      .nxt      (step_nxt),
      .ctl      (step_ctl)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      walker_in     = walker_ff;
      mark_hold_in  = mark_hold_ff;
      use_mem_in    = use_mem_ff;
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + AddrW'(1);
         if (clear_addr_ff == AddrW'(Depth - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
      if (fire) begin
         walker_in    = step_nxt;
         out_valid_in = 1'b1;
         use_mem_in   = step_ctl.moved;
         mark_hold_in = step_ctl.mark_wdata;
         if (step_ctl.restart) begin
            mark_hold_in  = '0;
            use_mem_in    = 1'b0;
            clear_busy_in = 1'b1;
            clear_addr_in = '0;
         end
      end
   end

   always_comb begin
      if (clear_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = fire && step_ctl.mark_we;
         mem_waddr = cell_addr(walker_ff.col, walker_ff.row);
         mem_wdata = step_ctl.mark_wdata;
      end
   end

   rhwf_ram #(
      .WIDTH(MARK_W),
      .DEPTH(Depth)
   ) u_marks (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(cell_addr(walker_in.col, walker_in.row)),
      .rdata(mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CFG_RESET;
         in_valid_ff   <= 1'b0;
         walker_ff     <= WalkerReset;
         mark_hold_ff  <= '0;
         use_mem_ff    <= 1'b0;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         in_valid_ff   <= in_valid_in;
         walker_ff     <= walker_in;
         mark_hold_ff  <= mark_hold_in;
         use_mem_ff    <= use_mem_in;
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_op_ff   <= req_tuser[0];
         in_open_ff <= req_tdata[3:0];
      end
      if (fire) begin
         out_data_ff <= {step_nxt.status, step_nxt.heading, step_nxt.row, step_nxt.col};
      end
   end

   a_restart_clears : assert property (@(posedge clock) disable iff (reset)
      (fire && (in_op_ff == OP_RESTART)) |=> (clear_busy_ff && !use_mem_ff))
      else $error("restart did not start a mark sweep");

   a_final_holds : assert property (@(posedge clock) disable iff (reset)
      (fire && (in_op_ff == OP_STEP) && (walker_ff.status != ST_RUN)) |=> $stable(walker_ff))
      else $error("walker state changed after a final status");

   a_mem_mark_no_sweep : assert property (@(posedge clock) disable iff (reset)
      use_mem_ff |-> !clear_busy_ff)
      else $error("mark taken from RAM during a sweep");

   a_move_one_cell : assert property (@(posedge clock) disable iff (reset)
      (fire && step_ctl.moved) |-> (walker_ff.status == ST_RUN) && !step_ctl.restart)
      else $error("move outside a running step");

endmodule

`default_nettype wire

/* rtl/core/rhwf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rhwf_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

/* rtl/core/rhwf_step.sv */
// Next-state logic of one walker item: restart, off-grid, loop and goal checks, right-hand rule.
`timescale 1ns / 1ps
`default_nettype none

module rhwf_step
   import rhwf_pkg::*;
#(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS
) (
   input  wire logic              opcode,
   input  wire logic [3:0]        open_dirs,
   input  wire cfg_type           cfg,
   input  wire walker_type        cur,
   input  wire logic [MARK_W-1:0] cur_mark,
   output walker_type             nxt,
   output step_ctl_type           ctl
);

   localparam int ColLim = (GRID_COLS < MAX_SIDE) ? GRID_COLS : MAX_SIDE;
   localparam int RowLim = (GRID_ROWS < MAX_SIDE) ? GRID_ROWS : MAX_SIDE;

   logic              cur_inside;
   logic              fwd_ok;
   logic [POS_W-1:0]  fwd_col;
   logic [POS_W-1:0]  fwd_row;
   logic [1:0]        right_dir;
   logic [1:0]        left_dir;
   logic [MARK_W-1:0] head_bit;

   assign cur_inside = ({1'b0, cur.col} < 7'(ColLim)) && ({1'b0, cur.row} < 7'(RowLim));
   assign right_dir  = cur.heading + 2'd1;
   assign left_dir   = cur.heading - 2'd1;
   assign head_bit   = MARK_W'(1) << cur.heading;

   always_comb begin
      fwd_col = cur.col;
      fwd_row = cur.row;
      fwd_ok  = 1'b0;
      case (cur.heading)
         2'd0: begin
            fwd_row = cur.row - 6'd1;
            fwd_ok  = (cur.row != '0);
         end
         2'd1: begin
            fwd_col = cur.col + 6'd1;
            fwd_ok  = (({1'b0, cur.col} + 7'd1) < 7'(ColLim));
         end
         2'd2: begin
            fwd_row = cur.row + 6'd1;
            fwd_ok  = (({1'b0, cur.row} + 7'd1) < 7'(RowLim));
         end
         default: begin
            fwd_col = cur.col - 6'd1;
            fwd_ok  = (cur.col != '0);
         end
      endcase
   end

   always_comb begin
      nxt            = cur;
      ctl.restart    = 1'b0;
      ctl.moved      = 1'b0;
      ctl.mark_we    = 1'b0;
      ctl.mark_wdata = cur_mark;
      if (opcode == OP_RESTART) begin
         nxt.col         = cfg.start_col;
         nxt.row         = cfg.start_row;
         nxt.heading     = cfg.start_dir;
         nxt.turned_last = 1'b0;
         nxt.status      = ST_RUN;
         ctl.restart     = 1'b1;
      end else if (cur.status == ST_RUN) begin
         if (!cur_inside) begin
            nxt.status = ST_OFF;
         end else if ((cur_mark & head_bit) != '0) begin
            nxt.status = ST_LOOP;
         end else if ((cur.col == cfg.goal_col) && (cur.row == cfg.goal_row)) begin
            nxt.status = ST_GOAL;
         end else if (cur.turned_last) begin
            nxt.turned_last = 1'b0;
            if (fwd_ok) begin
               nxt.col   = fwd_col;
               nxt.row   = fwd_row;
               ctl.moved = 1'b1;
            end else begin
               nxt.status = ST_OFF;
            end
         end else if (open_dirs[right_dir]) begin
            nxt.heading     = right_dir;
            nxt.turned_last = 1'b1;
         end else if (!open_dirs[cur.heading]) begin
            nxt.heading    = left_dir;
            ctl.mark_we    = 1'b1;
            ctl.mark_wdata = cur_mark | head_bit;
         end else begin
            ctl.mark_we    = 1'b1;
            ctl.mark_wdata = cur_mark | head_bit;
            if (fwd_ok) begin
               nxt.col   = fwd_col;
               nxt.row   = fwd_row;
               ctl.moved = 1'b1;
            end else begin
               nxt.status = ST_OFF;
            end
         end
      end
   end

endmodule

`default_nettype wire
